### rtl/tfu8_pkg.sv
`default_nettype none

package tfu8_pkg;

	typedef enum logic [1:0] {
		VERDICT_NONE     = 2'd0,
		VERDICT_NUL      = 2'd1,
		VERDICT_OVERSIZE = 2'd2,
		VERDICT_UTF8     = 2'd3
	} verdict_t;

	localparam logic [7:0] BYTE_NUL        = 8'h00;
	localparam logic [7:0] BYTE_ASCII_TOP  = 8'h7F;
	localparam logic [7:0] LEAD2_LOW       = 8'hC2;
	localparam logic [7:0] LEAD2_HIGH      = 8'hDF;
	localparam logic [7:0] LEAD3_LOW       = 8'hE0;
	localparam logic [7:0] LEAD3_HIGH      = 8'hEF;
	localparam logic [7:0] LEAD3_SURROGATE = 8'hED;
	localparam logic [7:0] LEAD4_LOW       = 8'hF0;
	localparam logic [7:0] LEAD4_HIGH      = 8'hF4;
	localparam logic [7:0] CONT_LOW        = 8'h80;
	localparam logic [7:0] CONT_HIGH       = 8'hBF;
	localparam logic [7:0] CONT_LOW_E0     = 8'hA0;
	localparam logic [7:0] CONT_HIGH_ED    = 8'h9F;
	localparam logic [7:0] CONT_LOW_F0     = 8'h90;
	localparam logic [7:0] CONT_HIGH_F4    = 8'h8F;

	localparam logic [15:0] CAP_RESET = 16'd4096;

endpackage

`default_nettype wire

### rtl/text_field_utf8_checker.sv
// Strict UTF-8 text field checker.
// Input channel (in_valid/in_ready): one byte of a field per transaction, with
// byte_value, last_byte marking the field's final byte, and empty_field for a
// field with no bytes (or to end a field in progress without another byte).
// Output channel (out_valid/out_ready): one verdict per field, given for the
// transaction that ends it: embedded NUL, oversized or invalid UTF-8, in that
// order of priority, or none when the field has none of these.
// Configuration channel (cfg_valid/cfg_ready, cfg_data): sets the byte cap;
// always ready; the user must write it only while no field is in progress, as
// the block itself does not enforce this. Throughput: one byte per cycle while
// no field end waits on a stalled verdict, set by the single input register
// feeding the decode and count logic into the result register.
// Reset clears all per-field state and sets the cap to 4096 (masked to
// LIMIT_BITS). When the receiver stalls, a waiting verdict is held and the
// input register still drains bytes that end no field; a field end waits in
// the input register, and in_ready drops only then.
`default_nettype none

module text_field_utf8_checker
	import tfu8_pkg::*;
#(
	parameter int LIMIT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  byte_value,
	input  wire logic        last_byte,
	input  wire logic        empty_field,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       verdict,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	localparam int CntW = LIMIT_BITS + 1;
	localparam logic [47:0] CapResetExt = {32'd0, CAP_RESET};

	logic [LIMIT_BITS-1:0] cap_q;
	logic [47:0]           cfg_ext;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       empty_s1;

	logic [1:0]      pend_q;
	logic [7:0]      lo_q;
	logic [7:0]      hi_q;
	logic            expect_q;
	logic            bad_q;
	logic            nul_q;
	logic [CntW-1:0] count_q;

	logic [1:0]      pend_d;
	logic [7:0]      lo_d;
	logic [7:0]      hi_d;
	logic            expect_d;
	logic            bad_d;
	logic            nul_d;
	logic [CntW-1:0] count_d;

	logic     finish;
	logic     advance;
	logic     out_valid_q;
	verdict_t verdict_q;
	verdict_t verdict_d;

	assign cfg_ready = 1'b1;
	assign cfg_ext   = {32'd0, cfg_data};
	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	assign finish   = empty_s1 | last_s1;
	assign advance  = valid_s1 & (~finish | ~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_comb begin
		logic [7:0]      lo_sel;
		logic [7:0]      hi_sel;
		logic [CntW-1:0] cap_ext;
		logic            bad_end;

		pend_d   = pend_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		expect_d = expect_q;
		bad_d    = bad_q;
		nul_d    = nul_q;
		count_d  = count_q;
		cap_ext  = {1'b0, cap_q};
		lo_sel   = expect_q ? lo_q : CONT_LOW;
		hi_sel   = expect_q ? hi_q : CONT_HIGH;

		if (!empty_s1) begin
			if (byte_s1 == BYTE_NUL) begin
				nul_d = 1'b1;
			end
			if (count_q <= cap_ext) begin
				count_d = count_q + CntW'(1);
			end
			if (pend_q != 2'd0) begin
				expect_d = 1'b0;
				if (byte_s1 < lo_sel || byte_s1 > hi_sel) begin
					bad_d  = 1'b1;
					pend_d = 2'd0;
				end else begin
					pend_d = pend_q - 2'd1;
				end
			end else begin
				lo_d = CONT_LOW;
				hi_d = CONT_HIGH;
				if (byte_s1 <= BYTE_ASCII_TOP) begin
					pend_d = 2'd0;
				end else if (byte_s1 >= LEAD2_LOW && byte_s1 <= LEAD2_HIGH) begin
					pend_d   = 2'd1;
					expect_d = 1'b1;
				end else if (byte_s1 >= LEAD3_LOW && byte_s1 <= LEAD3_HIGH) begin
					pend_d   = 2'd2;
					expect_d = 1'b1;
					if (byte_s1 == LEAD3_LOW) begin
						lo_d = CONT_LOW_E0;
					end
					if (byte_s1 == LEAD3_SURROGATE) begin
						hi_d = CONT_HIGH_ED;
					end
				end else if (byte_s1 >= LEAD4_LOW && byte_s1 <= LEAD4_HIGH) begin
					pend_d   = 2'd3;
					expect_d = 1'b1;
					if (byte_s1 == LEAD4_LOW) begin
						lo_d = CONT_LOW_F0;
					end
					if (byte_s1 == LEAD4_HIGH) begin
						hi_d = CONT_HIGH_F4;
					end
				end else begin
					bad_d = 1'b1;
				end
			end
		end

		bad_end = bad_d | (pend_d != 2'd0);
		if (nul_d) begin
			verdict_d = VERDICT_NUL;
		end else if (count_d > cap_ext) begin
			verdict_d = VERDICT_OVERSIZE;
		end else if (bad_end) begin
			verdict_d = VERDICT_UTF8;
		end else begin
			verdict_d = VERDICT_NONE;
		end

		if (finish) begin
			pend_d   = 2'd0;
			lo_d     = CONT_LOW;
			hi_d     = CONT_HIGH;
			expect_d = 1'b0;
			bad_d    = 1'b0;
			nul_d    = 1'b0;
			count_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapResetExt[LIMIT_BITS-1:0];
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_ext[LIMIT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= byte_value;
			last_s1  <= last_byte;
			empty_s1 <= empty_field;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 2'd0;
			lo_q     <= CONT_LOW;
			hi_q     <= CONT_HIGH;
			expect_q <= 1'b0;
			bad_q    <= 1'b0;
			nul_q    <= 1'b0;
			count_q  <= '0;
		end else if (advance) begin
			pend_q   <= pend_d;
			lo_q     <= lo_d;
			hi_q     <= hi_d;
			expect_q <= expect_d;
			bad_q    <= bad_d;
			nul_q    <= nul_d;
			count_q  <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && finish) begin
			verdict_q <= verdict_d;
		end
	end

	// The byte count never runs past one above the cap.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ({1'b0, cap_q} + CntW'(1)))
		else $error("byte count exceeds saturation point");

	// A pending first-continuation bound is only meaningful inside a sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		expect_q |-> (pend_q != 2'd0))
		else $error("first continuation expected with nothing pending");

	// A field end blocked by a stalled verdict stays in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && finish && out_valid_q && !out_ready)
		|=> (valid_s1 && $stable(byte_s1) && $stable(verdict_q)))
		else $error("field end or verdict lost under stall");

	// A verdict is registered only for a transaction that ends a field.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && !(valid_s1 && finish)) |=> !out_valid_q)
		else $error("verdict raised without a field end");

endmodule

`default_nettype wire

### verif/text_field_utf8_checker_test.sv
`default_nettype none

module text_field_utf8_checker_test
	import tfu8_pkg::*;
();

	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       empty;
	} field_byte_t;

	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_ITEMS = 130;
	localparam int LONG_STALL  = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  byte_value = 8'd0;
	logic        last_byte = 1'b0;
	logic        empty_field = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  verdict;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'd0;

	field_byte_t bytes_to_send[$];
	field_byte_t next_byte;
	logic [7:0]  field_bytes[$];
	verdict_t    verdicts_due[$];
	verdict_t    verdict_want;
	logic        in_done = 1'b0;
	int          queued_total = 0;
	int          accepted_total = 0;
	int          fail_count = 0;
	int          quiet_cycles = 0;
	int          tx_idle_pct = 24;
	int          rx_idle_pct = 67;
	int          rx_stall_cycles = 0;
	int          stall_requests = 0;
	int          stalls_started = 0;
	int          verdict_seen[4] = '{0, 0, 0, 0};
	int          caps_tried = 0;

	// Shadow of the checker state.
	logic [15:0] byte_cap = CAP_RESET;
	logic [1:0]  cont_left = 2'd0;
	logic [7:0]  first_lo = CONT_LOW;
	logic [7:0]  first_hi = CONT_HIGH;
	logic        first_next = 1'b0;
	logic        field_bad = 1'b0;
	logic        field_nul = 1'b0;
	logic [16:0] field_len = 17'd0;

	logic [15:0] cap_plan[6] = '{16'hFFFF, 16'd0, 16'd6, 16'd1, 16'd4096, 16'd12};

	text_field_utf8_checker u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.empty_field(empty_field),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.verdict    (verdict),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task decode_byte(input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		if (b == BYTE_NUL)
			field_nul = 1'b1;
		if (field_len <= {1'b0, byte_cap})
			field_len = field_len + 17'd1;
		if (cont_left != 2'd0) begin
			lo = first_next ? first_lo : CONT_LOW;
			hi = first_next ? first_hi : CONT_HIGH;
			first_next = 1'b0;
			if (b < lo || b > hi) begin
				field_bad = 1'b1;
				cont_left = 2'd0;
			end else
				cont_left = cont_left - 2'd1;
		end else begin
			first_lo = CONT_LOW;
			first_hi = CONT_HIGH;
			if (b > BYTE_ASCII_TOP) begin
				if (b >= LEAD2_LOW && b <= LEAD2_HIGH)
					cont_left = 2'd1;
				else if (b >= LEAD3_LOW && b <= LEAD3_HIGH) begin
					cont_left = 2'd2;
					if (b == LEAD3_LOW)
						first_lo = CONT_LOW_E0;
					if (b == LEAD3_SURROGATE)
						first_hi = CONT_HIGH_ED;
				end else if (b >= LEAD4_LOW && b <= LEAD4_HIGH) begin
					cont_left = 2'd3;
					if (b == LEAD4_LOW)
						first_lo = CONT_LOW_F0;
					if (b == LEAD4_HIGH)
						first_hi = CONT_HIGH_F4;
				end else
					field_bad = 1'b1;
				first_next = (cont_left != 2'd0);
			end
		end
	endtask

	task close_field(output verdict_t v);
		if (cont_left != 2'd0)
			field_bad = 1'b1;
		if (field_nul)
			v = VERDICT_NUL;
		else if (field_len > {1'b0, byte_cap})
			v = VERDICT_OVERSIZE;
		else if (field_bad)
			v = VERDICT_UTF8;
		else
			v = VERDICT_NONE;
		cont_left = 2'd0;
		first_lo = CONT_LOW;
		first_hi = CONT_HIGH;
		first_next = 1'b0;
		field_bad = 1'b0;
		field_nul = 1'b0;
		field_len = 17'd0;
	endtask

	always @(posedge clk) begin
		in_done <= in_valid && in_ready;
		if (cfg_valid && cfg_ready)
			byte_cap = cfg_data;
		if (in_valid && in_ready) begin
			accepted_total++;
			if (!empty_field)
				decode_byte(byte_value);
			if (empty_field || last_byte) begin
				close_field(verdict_want);
				verdicts_due.insert(verdicts_due.size(), verdict_want);
			end
		end
		if (out_valid && out_ready) begin
			if (!$isunknown(verdict))
				verdict_seen[verdict]++;
			if (verdicts_due.size() == 0) begin
				$display("%0t: verdict %0d arrived with nothing outstanding", $time, verdict);
				fail_count++;
			end else begin
				verdict_want = verdicts_due.pop_front();
				if (verdict !== verdict_want) begin
					$display("%0t: verdict mismatch, expected %s (%0d), got %0d",
						$time, verdict_want.name(), verdict_want, verdict);
					fail_count++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(negedge clk) begin
		if (!arst_n)
			in_valid <= 1'b0;
		else if (!in_valid || in_done) begin
			if (bytes_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				next_byte = bytes_to_send.pop_front();
				byte_value <= next_byte.value;
				last_byte <= next_byte.last;
				empty_field <= next_byte.empty;
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (stall_requests != stalls_started) begin
			out_ready <= 1'b0;
			stalls_started <= stalls_started + 1;
			rx_stall_cycles <= LONG_STALL;
		end else if (rx_stall_cycles > 0) begin
			out_ready <= 1'b0;
			rx_stall_cycles <= rx_stall_cycles - 1;
		end else
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
		$display("text_field_utf8_checker test failed");
		$finish;
	end

	task queue_item(input logic [7:0] b, input logic l, input logic e);
		bytes_to_send.insert(bytes_to_send.size(), field_byte_t'{value: b, last: l, empty: e});
		queued_total++;
	endtask

	task add_byte(input int unsigned v);
		field_bytes.insert(field_bytes.size(), v[7:0]);
	endtask

	function automatic logic [7:0] first_low(input logic [7:0] lead);
		return (lead == LEAD3_LOW) ? CONT_LOW_E0 : (lead == LEAD4_LOW) ? CONT_LOW_F0 : CONT_LOW;
	endfunction

	function automatic logic [7:0] first_high(input logic [7:0] lead);
		return (lead == LEAD3_SURROGATE) ? CONT_HIGH_ED :
			(lead == LEAD4_HIGH) ? CONT_HIGH_F4 : CONT_HIGH;
	endfunction

	// Mostly well-formed text with random content, with some faults, noise and empty fields.
	task automatic queue_field(input int max_chars);
		logic [7:0] lead;
		int style;
		int n;
		int kind;
		field_bytes.delete();
		style = $urandom_range(99);
		if (style < 8) begin
			queue_item(8'($urandom), 1'($urandom), 1'b1);
			return;
		end
		n = $urandom_range(max_chars, 1);
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(99);
			if (style < 20) begin
				add_byte($urandom_range(255));
				add_byte($urandom_range(255));
			end else if (kind < 35)
				add_byte($urandom_range(BYTE_ASCII_TOP, 1));
			else if (kind < 37)
				add_byte(32'(BYTE_NUL));
			else if (kind < 92) begin
				if (kind < 55)
					lead = 8'($urandom_range(LEAD2_HIGH, LEAD2_LOW));
				else if (kind < 75)
					lead = 8'($urandom_range(LEAD3_HIGH, LEAD3_LOW));
				else
					lead = 8'($urandom_range(LEAD4_HIGH, LEAD4_LOW));
				add_byte(32'(lead));
				add_byte($urandom_range(first_high(lead), first_low(lead)));
				if (lead >= LEAD3_LOW)
					add_byte($urandom_range(CONT_HIGH, CONT_LOW));
				if (lead >= LEAD4_LOW)
					add_byte($urandom_range(CONT_HIGH, CONT_LOW));
			end else begin
				case ($urandom_range(4))
					0: add_byte($urandom_range(CONT_HIGH, CONT_LOW));
					1: add_byte($urandom_range(1) ? LEAD2_LOW - $urandom_range(2, 1) :
						LEAD4_HIGH + $urandom_range(11, 1));
					2: begin
						case ($urandom_range(3))
							0: begin
								add_byte(32'(LEAD3_LOW));
								add_byte($urandom_range(CONT_LOW_E0 - 1, CONT_LOW));
							end
							1: begin
								add_byte(32'(LEAD3_SURROGATE));
								add_byte($urandom_range(CONT_HIGH, CONT_HIGH_ED + 1));
							end
							2: begin
								add_byte(32'(LEAD4_LOW));
								add_byte($urandom_range(CONT_LOW_F0 - 1, CONT_LOW));
							end
							default: begin
								add_byte(32'(LEAD4_HIGH));
								add_byte($urandom_range(CONT_HIGH, CONT_HIGH_F4 + 1));
							end
						endcase
					end
					3: begin
						lead = 8'($urandom_range(LEAD4_HIGH, LEAD2_LOW));
						add_byte(32'(lead));
						if (lead >= LEAD4_LOW && $urandom_range(1))
							add_byte($urandom_range(first_high(lead), first_low(lead)));
					end
					default: add_byte($urandom_range(255));
				endcase
			end
		end
		if ($urandom_range(99) < 6) begin
			foreach (field_bytes[i])
				queue_item(field_bytes[i], 1'b0, 1'b0);
			queue_item(8'($urandom), 1'($urandom), 1'b1);
		end else begin
			foreach (field_bytes[i])
				queue_item(field_bytes[i], i == field_bytes.size() - 1, 1'b0);
		end
	endtask

	task write_cap(input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		caps_tried++;
	endtask

	task wait_idle;
		@(negedge clk);
		while (accepted_total != queued_total || verdicts_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int first_item;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed fields at the reset cap.
		queue_item(8'hFF, 1'b1, 1'b1);
		queue_item(BYTE_NUL, 1'b1, 1'b0);
		queue_item(CONT_LOW, 1'b1, 1'b0);
		queue_item(LEAD2_LOW - 8'd1, 1'b1, 1'b0);
		queue_item(8'hFF, 1'b1, 1'b0);
		queue_item(LEAD2_LOW, 1'b0, 1'b0);
		queue_item(BYTE_NUL, 1'b0, 1'b1);
		queue_item(LEAD3_LOW, 1'b0, 1'b0);
		queue_item(CONT_HIGH_ED, 1'b0, 1'b0);
		queue_item(CONT_LOW, 1'b1, 1'b0);
		queue_item(LEAD3_SURROGATE, 1'b0, 1'b0);
		queue_item(CONT_HIGH_ED, 1'b0, 1'b0);
		queue_item(CONT_HIGH, 1'b1, 1'b0);
		queue_item(LEAD4_LOW, 1'b0, 1'b0);
		queue_item(CONT_LOW_F0, 1'b0, 1'b0);
		queue_item(CONT_LOW, 1'b0, 1'b0);
		queue_item(CONT_LOW, 1'b1, 1'b0);
		queue_item(LEAD4_HIGH, 1'b0, 1'b0);
		queue_item(CONT_LOW_F0, 1'b0, 1'b0);
		queue_item(CONT_LOW, 1'b0, 1'b0);
		queue_item(CONT_LOW, 1'b1, 1'b0);
		queue_item(BYTE_ASCII_TOP, 1'b0, 1'b0);
		queue_item(BYTE_NUL, 1'b0, 1'b0);
		queue_item(8'hFF, 1'b1, 1'b0);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			@(posedge clk);
			tx_idle_pct = (p < 2) ? 24 : (p < 4) ? 67 : 0;
			rx_idle_pct = (p < 2) ? 67 : (p < 4) ? 24 : 0;
			write_cap(cap_plan[p]);
			@(posedge clk);
			// The receiver holds off while the sender keeps offering, so the input backs up.
			if (p == 4)
				stall_requests++;
			first_item = queued_total;
			while (queued_total - first_item < PHASE_ITEMS)
				queue_field(($urandom_range(7) == 0) ? 12 : 4);
			wait_idle();
		end

		repeat (6) @(negedge clk);
		$display("Sent %0d transactions under %0d cap settings plus the reset cap.",
			accepted_total, caps_tried);
		$display("Verdicts seen: none %0d, nul %0d, oversized %0d, invalid utf8 %0d.",
			verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3]);
		if (fail_count == 0 && verdicts_due.size() == 0)
			$display("text_field_utf8_checker test passed");
		else
			$display("text_field_utf8_checker test failed");
		$finish;
	end

endmodule

`default_nettype wire
